// ===== hw/rtl/imadec_pkg.sv =====
// Shared types, constants and lookup tables for the IMA-ADPCM decoder.
package imadec_pkg;

    typedef logic [6:0]          step_pos_t;
    typedef logic [14:0]         step_size_t;
    typedef logic signed [15:0]  pcm_t;
    typedef logic signed [4:0]   pos_move_t;

    localparam step_pos_t MaxStepPos = 7'd88;
    localparam pcm_t      PcmMax     = 16'sh7FFF;
    localparam pcm_t      PcmMin     = 16'sh8000;

    function automatic step_size_t step_size(input step_pos_t pos);
        case (pos)
            7'd0:  return 15'd7;     7'd1:  return 15'd8;     7'd2:  return 15'd9;
            7'd3:  return 15'd10;    7'd4:  return 15'd11;    7'd5:  return 15'd12;
            7'd6:  return 15'd13;    7'd7:  return 15'd14;    7'd8:  return 15'd16;
            7'd9:  return 15'd17;    7'd10: return 15'd19;    7'd11: return 15'd21;
            7'd12: return 15'd23;    7'd13: return 15'd25;    7'd14: return 15'd28;
            7'd15: return 15'd31;    7'd16: return 15'd34;    7'd17: return 15'd37;
            7'd18: return 15'd41;    7'd19: return 15'd45;    7'd20: return 15'd50;
            7'd21: return 15'd55;    7'd22: return 15'd60;    7'd23: return 15'd66;
            7'd24: return 15'd73;    7'd25: return 15'd80;    7'd26: return 15'd88;
            7'd27: return 15'd97;    7'd28: return 15'd107;   7'd29: return 15'd118;
            7'd30: return 15'd130;   7'd31: return 15'd143;   7'd32: return 15'd157;
            7'd33: return 15'd173;   7'd34: return 15'd190;   7'd35: return 15'd209;
            7'd36: return 15'd230;   7'd37: return 15'd253;   7'd38: return 15'd279;
            7'd39: return 15'd307;   7'd40: return 15'd337;   7'd41: return 15'd371;
            7'd42: return 15'd408;   7'd43: return 15'd449;   7'd44: return 15'd494;
            7'd45: return 15'd544;   7'd46: return 15'd598;   7'd47: return 15'd658;
            7'd48: return 15'd724;   7'd49: return 15'd796;   7'd50: return 15'd876;
            7'd51: return 15'd963;   7'd52: return 15'd1060;  7'd53: return 15'd1166;
            7'd54: return 15'd1282;  7'd55: return 15'd1411;  7'd56: return 15'd1552;
            7'd57: return 15'd1707;  7'd58: return 15'd1878;  7'd59: return 15'd2066;
            7'd60: return 15'd2272;  7'd61: return 15'd2499;  7'd62: return 15'd2749;
            7'd63: return 15'd3024;  7'd64: return 15'd3327;  7'd65: return 15'd3660;
            7'd66: return 15'd4026;  7'd67: return 15'd4428;  7'd68: return 15'd4871;
            7'd69: return 15'd5358;  7'd70: return 15'd5894;  7'd71: return 15'd6484;
            7'd72: return 15'd7132;  7'd73: return 15'd7845;  7'd74: return 15'd8630;
            7'd75: return 15'd9493;  7'd76: return 15'd10442; 7'd77: return 15'd11487;
            7'd78: return 15'd12635; 7'd79: return 15'd13899; 7'd80: return 15'd15289;
            7'd81: return 15'd16818; 7'd82: return 15'd18500; 7'd83: return 15'd20350;
            7'd84: return 15'd22385; 7'd85: return 15'd24623; 7'd86: return 15'd27086;
            7'd87: return 15'd29794;
            default: return 15'd32767;
        endcase
    endfunction

    function automatic pos_move_t pos_move(input logic [2:0] mag);
        case (mag) inside
            3'd0, 3'd1, 3'd2, 3'd3: return -5'sd1;
            3'd4:                   return 5'sd2;
            3'd5:                   return 5'sd4;
            3'd6:                   return 5'sd6;
            default:                return 5'sd8;
        endcase
    endfunction

endpackage

// ===== hw/rtl/ima_adpcm_decoder.sv =====
// IMA-ADPCM decoder top level: input register, nibble update, output register.
// A decode beat writes its high-nibble sample, then its low-nibble sample, to the output
// register, with one nibble update of predictor and step index per cycle while the output
// register is free; the next byte is taken in the cycle its low nibble is decoded. Sync
// beats do not wait on the output. Synchronous active-low reset clears predictor and index.
module ima_adpcm_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_mode,
    input  logic [7:0]          s_code_byte,
    input  logic                s_frame_end,
    input  logic signed [15:0]  s_load_predictor,
    input  logic signed [7:0]   s_load_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_pcm_sample,
    output logic                m_last_of_frame
);

    logic                      in_valid_reg;
    logic                      in_mode_reg;
    logic [7:0]                in_byte_reg;
    logic                      in_fend_reg;
    imadec_pkg::pcm_t          in_pred_reg;
    logic signed [7:0]         in_idx_reg;
    logic                      phase_reg;
    imadec_pkg::pcm_t          pred_reg;
    imadec_pkg::step_pos_t     pos_reg;
    logic                      m_valid_reg;
    imadec_pkg::pcm_t          pcm_reg;
    logic                      last_reg;

    logic                      out_free;
    logic                      nib_go;
    logic                      sync_go;
    logic                      in_done;
    logic                      accept;
    logic [3:0]                nib;
    imadec_pkg::step_size_t    step;
    logic [16:0]               diff;
    logic signed [17:0]        sum;
    imadec_pkg::pcm_t          pred_next;
    imadec_pkg::pos_move_t     pos_step;
    logic signed [7:0]         pos_sum;
    imadec_pkg::step_pos_t     pos_next;
    imadec_pkg::step_pos_t     load_pos;

    assign out_free = !m_valid_reg || m_ready;
    assign nib_go   = in_valid_reg && !in_mode_reg && out_free;
    assign sync_go  = in_valid_reg && in_mode_reg;
    assign in_done  = sync_go || (nib_go && phase_reg);
    assign s_ready  = !in_valid_reg || in_done;
    assign accept   = s_valid && s_ready;

    always_comb begin
        nib  = phase_reg ? in_byte_reg[3:0] : in_byte_reg[7:4];
        step = imadec_pkg::step_size(pos_reg);
        diff = {2'b00, step} >> 3;
        if (nib[0]) begin
            diff = diff + ({2'b00, step} >> 2);
        end
        if (nib[1]) begin
            diff = diff + ({2'b00, step} >> 1);
        end
        if (nib[2]) begin
            diff = diff + {2'b00, step};
        end
        if (nib[3]) begin
            sum = {{2{pred_reg[15]}}, pred_reg} - $signed({1'b0, diff});
        end else begin
            sum = {{2{pred_reg[15]}}, pred_reg} + $signed({1'b0, diff});
        end
        if (sum > 18'sd32767) begin
            pred_next = imadec_pkg::PcmMax;
        end else if (sum < -18'sd32768) begin
            pred_next = imadec_pkg::PcmMin;
        end else begin
            pred_next = sum[15:0];
        end

        pos_step = imadec_pkg::pos_move(nib[2:0]);
        pos_sum  = $signed({1'b0, pos_reg}) + {{3{pos_step[4]}}, pos_step};
        if (pos_sum[7]) begin
            pos_next = '0;
        end else if (pos_sum[6:0] > imadec_pkg::MaxStepPos) begin
            pos_next = imadec_pkg::MaxStepPos;
        end else begin
            pos_next = pos_sum[6:0];
        end

        if (in_idx_reg[7]) begin
            load_pos = '0;
        end else if (in_idx_reg[6:0] > imadec_pkg::MaxStepPos) begin
            load_pos = imadec_pkg::MaxStepPos;
        end else begin
            load_pos = in_idx_reg[6:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
            pred_reg     <= '0;
            pos_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                in_valid_reg <= 1'b1;
                phase_reg    <= 1'b0;
            end else begin
                if (in_done) begin
                    in_valid_reg <= 1'b0;
                end
                if (nib_go) begin
                    phase_reg <= !phase_reg;
                end
            end
            if (sync_go) begin
                pred_reg <= in_pred_reg;
                pos_reg  <= load_pos;
            end else if (nib_go) begin
                pred_reg <= pred_next;
                pos_reg  <= pos_next;
            end
            if (nib_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_mode_reg <= s_mode;
            in_byte_reg <= s_code_byte;
            in_fend_reg <= s_frame_end;
            in_pred_reg <= s_load_predictor;
            in_idx_reg  <= s_load_index;
        end
        if (nib_go) begin
            pcm_reg  <= pred_next;
            last_reg <= phase_reg && in_fend_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pcm_sample    = pcm_reg;
    assign m_last_of_frame = last_reg;

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= imadec_pkg::MaxStepPos)
        else $error("step index left its range");

    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (nib_go && !phase_reg) |=> !last_reg)
        else $error("first sample of a byte flagged as frame end");

    a_decode_starts_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_mode) |=> (in_valid_reg && !phase_reg && !in_mode_reg))
        else $error("decode beat did not start on the high nibble");

endmodule
